FILE: rtl/utm_pkg.sv
// ----------------------------------------------------------------------------
// utm_pkg: shared types and constants of the UTF-8 text extent measurer
// Holds the register indexes, the reset values of the registers, the UTF-8
// decode constants, and the structs passed between the block's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package utm_pkg;

	// Default sizes for the top-level parameters.
	localparam int GLYPH_TABLE_DEPTH_DEF = 128;
	localparam int EXTENT_BITS_DEF       = 16;

	// Output and counter widths are fixed at 16 bits.
	localparam int          OUT_W   = 16;
	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	// Decoded code points are 21 bits wide.
	localparam int CP_W = 21;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_GLYPH_HEIGHT      = 3'd0,
		CFG_MONO_WIDTH        = 3'd1,
		CFG_PROPORTIONAL_MODE = 3'd2,
		CFG_GLYPH_GAP         = 3'd3,
		CFG_GLYPH_COUNT       = 3'd4,
		CFG_BYTE_LIMIT        = 3'd5
	} cfg_idx_t;

	// Register reset values.
	localparam logic [7:0]  RST_GLYPH_HEIGHT = 8'd9;
	localparam logic [7:0]  RST_MONO_WIDTH   = 8'd8;
	localparam logic        RST_PROP_MODE    = 1'b0;
	localparam logic [7:0]  RST_GLYPH_GAP    = 8'd1;
	localparam logic [7:0]  RST_GLYPH_COUNT  = 8'd96;
	localparam logic [15:0] RST_BYTE_LIMIT   = 16'd0;

	// Input commands.
	localparam logic CMD_TEXT  = 1'b0;
	localparam logic CMD_TABLE = 1'b1;

	// Result status codes.
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_MISSING = 1'b1;

	// UTF-8 decode constants.
	localparam logic [7:0]      CONT_MASK   = 8'h3F;
	localparam logic [7:0]      ASCII_MAX   = 8'h7F;
	localparam logic [7:0]      LEAD2_MAX   = 8'hDF;
	localparam logic [7:0]      LEAD3_MAX   = 8'hEF;
	localparam logic [7:0]      LEAD4_MAX   = 8'hF7;
	localparam logic [CP_W-1:0] FIRST_GLYPH = 21'h20;
	localparam logic [CP_W-1:0] CP_SPACE    = 21'h20;
	localparam logic [CP_W-1:0] CP_NEWLINE  = 21'h0A;

	// What a decoded byte asks of the extent stage.
	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_NEWLINE = 3'd1,
		EV_GLYPH   = 3'd2,
		EV_END     = 3'd3,
		EV_ERROR   = 3'd4
	} ev_kind_t;

	// Configuration register file.
	typedef struct packed {
		logic [7:0]  glyph_height;
		logic [7:0]  mono_width;
		logic        proportional_mode;
		logic [7:0]  glyph_gap;
		logic [7:0]  glyph_count;
		logic [15:0] byte_limit;
	} cfg_t;

	// One input item.
	typedef struct packed {
		logic       command;
		logic       first_byte;
		logic [7:0] byte_value;
		logic [6:0] table_index;
		logic [7:0] table_width;
	} item_t;

	// Decode stage to extent stage.
	typedef struct packed {
		ev_kind_t    kind;
		logic        clear;
		logic        use_table;
		logic [15:0] count;
	} glyph_ev_t;

endpackage

`default_nettype wire

FILE: rtl/utm_decode.sv
// ----------------------------------------------------------------------------
// utm_decode: UTF-8 decode stage
// Decodes one byte per cycle while go is high, keeps the byte and code point counters, owns
// the glyph width memory and issues one registered event per item.
// ----------------------------------------------------------------------------
`default_nettype none

module utm_decode #(
	parameter int GLYPH_TABLE_DEPTH = utm_pkg::GLYPH_TABLE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire utm_pkg::item_t    item,
	input  wire utm_pkg::cfg_t     cfg,
	output utm_pkg::glyph_ev_t     ev_s2,
	output logic [7:0]             tab_width_s2
);

	localparam int IDX_W = (GLYPH_TABLE_DEPTH > 1) ? $clog2(GLYPH_TABLE_DEPTH) : 1;

	// Glyph width memory.
	logic [7:0] width_mem [GLYPH_TABLE_DEPTH];

	// Decoder state.
	logic [1:0]              pend_q, pend_n;
	logic [utm_pkg::CP_W-1:0] acc_q, acc_n;
	logic                    bad_q, bad_n;
	logic [15:0]             bytes_q, bytes_n;
	logic [15:0]             cnt_q, cnt_n;
	logic                    done_q, done_n;

	logic                     cp_ok;
	logic [utm_pkg::CP_W-1:0] cp;
	logic [utm_pkg::CP_W-1:0] gidx;
	logic                     skip_byte;
	logic [7:0]               b;
	utm_pkg::glyph_ev_t       ev;
	logic                     wr_ok;

	assign b    = item.byte_value;
	assign gidx = cp - utm_pkg::FIRST_GLYPH;

	// Bytes that cannot start a sequence.
	always_comb begin
		skip_byte = 1'b0;
		if (b inside {[8'h80:8'hBF], 8'hC0, 8'hC1, 8'hFE, 8'hFF}) begin
			skip_byte = 1'b1;
		end
	end

	// Next decoder state and the event for this item.
	always_comb begin
		pend_n       = pend_q;
		acc_n        = acc_q;
		bad_n        = bad_q;
		bytes_n      = bytes_q;
		cnt_n        = cnt_q;
		done_n       = done_q;
		cp_ok        = 1'b0;
		cp           = '0;
		ev.kind      = utm_pkg::EV_NONE;
		ev.clear     = 1'b0;
		ev.use_table = 1'b0;
		if (item.command == utm_pkg::CMD_TEXT) begin
			if (item.first_byte) begin
				pend_n   = '0;
				acc_n    = '0;
				bad_n    = 1'b0;
				bytes_n  = '0;
				cnt_n    = '0;
				done_n   = 1'b0;
				ev.clear = 1'b1;
			end
			if (!done_n) begin
				if (bytes_n != utm_pkg::CNT_MAX) begin
					bytes_n = bytes_n + 16'd1;
				end
				if (pend_n != 2'd0) begin
					// Continuation bytes are taken without a check.
					acc_n  = {acc_n[utm_pkg::CP_W-7:0], b[5:0] & utm_pkg::CONT_MASK[5:0]};
					pend_n = pend_n - 2'd1;
					if (pend_n == 2'd0) begin
						cp_ok = 1'b1;
						if (bad_n) begin
							bad_n = 1'b0;
							cp    = utm_pkg::CP_SPACE;
						end else begin
							cp = acc_n;
						end
					end
				end else if (!skip_byte) begin
					if (b <= utm_pkg::ASCII_MAX) begin
						cp_ok = 1'b1;
						cp    = utm_pkg::CP_W'(b);
					end else if (b <= utm_pkg::LEAD2_MAX) begin
						acc_n  = utm_pkg::CP_W'(b[4:0]);
						pend_n = 2'd1;
					end else if (b <= utm_pkg::LEAD3_MAX) begin
						acc_n  = utm_pkg::CP_W'(b[3:0]);
						pend_n = 2'd2;
					end else if (b <= utm_pkg::LEAD4_MAX) begin
						acc_n  = utm_pkg::CP_W'(b[2:0]);
						pend_n = 2'd3;
					end else begin
						// Five and six byte leads become a space after three more bytes.
						acc_n  = '0;
						pend_n = 2'd3;
						bad_n  = 1'b1;
					end
				end
				// Classify the completed code point.
				if (cp_ok) begin
					if (cp == '0 || (cfg.byte_limit != 16'd0 && bytes_n >= cfg.byte_limit)) begin
						ev.kind = utm_pkg::EV_END;
						done_n  = 1'b1;
					end else begin
						if (cnt_n != utm_pkg::CNT_MAX) begin
							cnt_n = cnt_n + 16'd1;
						end
						if (cp == utm_pkg::CP_NEWLINE) begin
							ev.kind = utm_pkg::EV_NEWLINE;
						end else if (!cfg.proportional_mode) begin
							ev.kind = utm_pkg::EV_GLYPH;
						end else if (cp < utm_pkg::FIRST_GLYPH
								|| gidx >= utm_pkg::CP_W'(cfg.glyph_count)
								|| gidx >= utm_pkg::CP_W'(GLYPH_TABLE_DEPTH)) begin
							ev.kind = utm_pkg::EV_ERROR;
							done_n  = 1'b1;
						end else begin
							ev.kind      = utm_pkg::EV_GLYPH;
							ev.use_table = 1'b1;
						end
					end
				end
			end
		end
		ev.count = cnt_n;
	end

	// Decoder state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			acc_q   <= '0;
			bad_q   <= 1'b0;
			bytes_q <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b1;
		end else if (go) begin
			pend_q  <= pend_n;
			acc_q   <= acc_n;
			bad_q   <= bad_n;
			bytes_q <= bytes_n;
			cnt_q   <= cnt_n;
			done_q  <= done_n;
		end
	end

	// Event register.
	always_ff @(posedge clk) begin
		if (go) begin
			ev_s2 <= ev;
		end
	end

	// Width memory: one write port for table beats, one registered read.
	assign wr_ok = (item.command == utm_pkg::CMD_TABLE)
			&& (32'(item.table_index) < 32'(GLYPH_TABLE_DEPTH));

	always_ff @(posedge clk) begin
		if (go && wr_ok) begin
			width_mem[IDX_W'(item.table_index)] <= item.table_width;
		end
		if (go && ev.use_table) begin
			tab_width_s2 <= width_mem[IDX_W'(gidx)];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/utm_extent.sv
// ----------------------------------------------------------------------------
// utm_extent: pen tracking and result register
// Applies each decode event to the pen, widest line and line position, and
// loads the result register when a string ends.
// ----------------------------------------------------------------------------
`default_nettype none

module utm_extent #(
	parameter int EXTENT_BITS = utm_pkg::EXTENT_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                go,
	input  wire utm_pkg::glyph_ev_t  ev,
	input  wire logic [7:0]          tab_width,
	input  wire utm_pkg::cfg_t       cfg,
	input  wire logic                out_stall,
	output logic                     out_free,
	output logic                     out_valid,
	output logic                     status,
	output logic [15:0]              width_px,
	output logic [15:0]              height_px,
	output logic [15:0]              char_count
);

	localparam int                 EB      = EXTENT_BITS;
	localparam int                 WIDE_W  = 34;
	localparam logic [EB-1:0]      EXT_MAX = '1;
	localparam logic [WIDE_W-1:0]  OUT_MAX = WIDE_W'(utm_pkg::CNT_MAX);

	logic [EB-1:0]   pen_q, max_q, line_q;
	logic [EB-1:0]   pen_b, max_b, line_b;
	logic [EB-1:0]   pen_n, max_n, line_n;
	logic [7:0]      gw;
	logic [EB+1:0]   pen_sum;
	logic [EB-1:0]   pen_sat;
	logic [EB:0]     line_sum;
	logic [EB-1:0]   line_sat;
	logic [WIDE_W-1:0] w_max, w_sp, w_diff, h_wide;
	logic [15:0]     w_out, h_out;
	logic            is_result;

	// A new string starts from a clean pen.
	assign pen_b  = ev.clear ? '0 : pen_q;
	assign max_b  = ev.clear ? '0 : max_q;
	assign line_b = ev.clear ? '0 : line_q;

	// Glyph advance and line step, both saturating.
	assign gw       = ev.use_table ? tab_width : cfg.mono_width;
	assign pen_sum  = (EB+2)'(pen_b) + (EB+2)'(gw) + (EB+2)'(cfg.glyph_gap);
	assign pen_sat  = (pen_sum > (EB+2)'(EXT_MAX)) ? EXT_MAX : pen_sum[EB-1:0];
	assign line_sum = (EB+1)'(line_b) + (EB+1)'(cfg.glyph_height);
	assign line_sat = (line_sum > (EB+1)'(EXT_MAX)) ? EXT_MAX : line_sum[EB-1:0];

	// Next pen state.
	always_comb begin
		pen_n  = pen_b;
		max_n  = max_b;
		line_n = line_b;
		case (ev.kind)
			utm_pkg::EV_NEWLINE: begin
				line_n = line_sat;
				pen_n  = '0;
			end
			utm_pkg::EV_GLYPH: begin
				pen_n = pen_sat;
				if (pen_sat > max_b) begin
					max_n = pen_sat;
				end
			end
			default: begin
				pen_n = pen_b;
			end
		endcase
	end

	// Final extent: widest line less the trailing spacing, and last line bottom.
	assign w_max  = WIDE_W'(max_b);
	assign w_sp   = WIDE_W'(cfg.glyph_gap);
	assign w_diff = (w_max > w_sp) ? (w_max - w_sp) : '0;
	assign w_out  = (w_diff > OUT_MAX) ? utm_pkg::CNT_MAX : w_diff[15:0];
	assign h_wide = WIDE_W'(line_sum);
	assign h_out  = (h_wide > OUT_MAX) ? utm_pkg::CNT_MAX : h_wide[15:0];

	assign is_result = (ev.kind == utm_pkg::EV_END) || (ev.kind == utm_pkg::EV_ERROR);
	assign out_free  = !out_valid || !out_stall;

	// Pen state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_q  <= '0;
			max_q  <= '0;
			line_q <= '0;
		end else if (go) begin
			pen_q  <= pen_n;
			max_q  <= max_n;
			line_q <= line_n;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (go && is_result) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (go && is_result) begin
			char_count <= ev.count;
			if (ev.kind == utm_pkg::EV_END) begin
				status    <= utm_pkg::STATUS_OK;
				width_px  <= w_out;
				height_px <= h_out;
			end else begin
				status    <= utm_pkg::STATUS_MISSING;
				width_px  <= '0;
				height_px <= '0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/utf8_text_extent_measure.sv
// ----------------------------------------------------------------------------
// utf8_text_extent_measure: UTF-8 string extent measurer
// Decodes a UTF-8 string one byte per beat and reports its rendered width,
// height and code point count when the string ends.
// ----------------------------------------------------------------------------
// Usage:
//  The input channel (in_valid / in_stall) carries one beat per byte of text
//  or one width table write. A beat with first_byte set starts a new string.
//  A string ends on a zero code point, on reaching byte_limit, or on a glyph
//  missing from the font; that beat produces one result beat on the output
//  channel (out_valid / out_stall). All other beats produce no result.
//  Throughput is one beat per cycle while the output does not stall: an input
//  register, a decode stage and a pen stage follow in that order, with the
//  width memory read registered alongside the decode stage. The skid
//  register is only used while the input register is blocked. out_valid rises
//  once the ending byte has passed the input register and the decode stage.
//  When the receiver stalls, the result register holds; the pipeline keeps
//  taking beats until a second result event waits in front of the result
//  register. The input register and then the skid register fill behind it,
//  and in_stall rises once the skid register holds a beat. The user writes
//  registers through cfg_valid / cfg_ready / cfg_index / cfg_data only while
//  no string is in flight, unenforced by the block. Reset restores register
//  defaults and leaves the block idle until a first_byte beat; the width
//  table is not cleared and must be loaded before proportional mode is used.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_text_extent_measure #(
	parameter int GLYPH_TABLE_DEPTH = utm_pkg::GLYPH_TABLE_DEPTH_DEF,
	parameter int EXTENT_BITS       = utm_pkg::EXTENT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// Input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command,
	input  wire logic        first_byte,
	input  wire logic [7:0]  byte_value,
	input  wire logic [6:0]  table_index,
	input  wire logic [7:0]  table_width,
	// Output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             status,
	output logic [15:0]      width_px,
	output logic [15:0]      height_px,
	output logic [15:0]      char_count
);

	utm_pkg::cfg_t      cfg_q;
	utm_pkg::item_t     in_item, skid_q, item_s1;
	logic               skid_full_q, s1_v_q, s2_v_q;
	logic               in_acc, s1_take, s1_go, s2_take, s2_go, s2_res, out_free;
	utm_pkg::glyph_ev_t ev_s2;
	logic [7:0]         tab_width_s2;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glyph_height      <= utm_pkg::RST_GLYPH_HEIGHT;
			cfg_q.mono_width        <= utm_pkg::RST_MONO_WIDTH;
			cfg_q.proportional_mode <= utm_pkg::RST_PROP_MODE;
			cfg_q.glyph_gap         <= utm_pkg::RST_GLYPH_GAP;
			cfg_q.glyph_count       <= utm_pkg::RST_GLYPH_COUNT;
			cfg_q.byte_limit        <= utm_pkg::RST_BYTE_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				utm_pkg::CFG_GLYPH_HEIGHT:      cfg_q.glyph_height      <= cfg_data[7:0];
				utm_pkg::CFG_MONO_WIDTH:        cfg_q.mono_width        <= cfg_data[7:0];
				utm_pkg::CFG_PROPORTIONAL_MODE: cfg_q.proportional_mode <= cfg_data[0];
				utm_pkg::CFG_GLYPH_GAP:         cfg_q.glyph_gap         <= cfg_data[7:0];
				utm_pkg::CFG_GLYPH_COUNT:       cfg_q.glyph_count       <= cfg_data[7:0];
				utm_pkg::CFG_BYTE_LIMIT:        cfg_q.byte_limit        <= cfg_data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Pipeline flow control.
	assign in_item  = '{command, first_byte, byte_value, table_index, table_width};
	assign in_stall = skid_full_q;
	assign in_acc   = in_valid && !skid_full_q;
	assign s2_res   = (ev_s2.kind == utm_pkg::EV_END) || (ev_s2.kind == utm_pkg::EV_ERROR);
	assign s2_go    = s2_v_q && (!s2_res || out_free);
	assign s2_take  = !s2_v_q || s2_go;
	assign s1_go    = s1_v_q && s2_take;
	assign s1_take  = !s1_v_q || s1_go;

	// Skid and input stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
			s1_v_q      <= 1'b0;
			s2_v_q      <= 1'b0;
		end else begin
			if (s1_take) begin
				s1_v_q      <= skid_full_q || in_acc;
				skid_full_q <= 1'b0;
			end else if (in_acc) begin
				skid_full_q <= 1'b1;
			end
			if (s2_take) begin
				s2_v_q <= s1_go;
			end
		end
	end

	// Skid and input stage payload.
	always_ff @(posedge clk) begin
		if (s1_take) begin
			item_s1 <= skid_full_q ? skid_q : in_item;
		end else if (in_acc) begin
			skid_q <= in_item;
		end
	end

	utm_decode #(
		.GLYPH_TABLE_DEPTH(GLYPH_TABLE_DEPTH)
	) u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (s1_go),
		.item         (item_s1),
		.cfg          (cfg_q),
		.ev_s2        (ev_s2),
		.tab_width_s2 (tab_width_s2)
	);

	utm_extent #(
		.EXTENT_BITS(EXTENT_BITS)
	) u_extent (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (s2_go),
		.ev         (ev_s2),
		.tab_width  (tab_width_s2),
		.cfg        (cfg_q),
		.out_stall  (out_stall),
		.out_free   (out_free),
		.out_valid  (out_valid),
		.status     (status),
		.width_px   (width_px),
		.height_px  (height_px),
		.char_count (char_count)
	);

	// The skid register only fills behind an occupied input stage.
	a_skid_behind_s1: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> s1_v_q)
		else $error("skid register full while input stage empty");

	// A beat taken while the input stage is blocked lands in the skid register.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s1_v_q && !s1_go) |=> skid_full_q)
		else $error("accepted beat not held in skid register");

	// A result event waits in the decode stage while the result register is blocked.
	a_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_v_q && s2_res && out_valid && out_stall) |=> (s2_v_q && out_valid))
		else $error("result event lost behind a stalled result register");

	// The pen stage never drops a result while the receiver stalls.
	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result register cleared while stalled");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the UTF-8 text extent measurer
// Streams UTF-8 strings, width table writes and register changes into the
// block, predicts every measured extent in a scoreboard and compares each
// result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------

localparam int          GLYPH_DEPTH = utm_pkg::GLYPH_TABLE_DEPTH_DEF;
localparam int unsigned EXT_MAX     = (1 << utm_pkg::EXTENT_BITS_DEF) - 1;

// One predicted result beat.
typedef struct packed {
	logic        status;
	logic [15:0] width_px;
	logic [15:0] height_px;
	logic [15:0] char_count;
} extent_t;

class extent_scoreboard;
	// Register copies.
	logic [7:0]  glyph_height;
	logic [7:0]  mono_width;
	logic        proportional_mode;
	logic [7:0]  glyph_gap;
	logic [7:0]  glyph_count;
	logic [15:0] byte_limit;

	// String state.
	int unsigned seq_left;
	logic [20:0] code;
	bit          space_seq;
	int unsigned consumed;
	int unsigned pen_x;
	int unsigned max_x;
	int unsigned line_y;
	int unsigned points;
	bit          in_string;
	logic [7:0]  widths [GLYPH_DEPTH];

	extent_t     pending_extents [$];
	int unsigned errors;

	function new();
		glyph_height      = utm_pkg::RST_GLYPH_HEIGHT;
		mono_width        = utm_pkg::RST_MONO_WIDTH;
		proportional_mode = utm_pkg::RST_PROP_MODE;
		glyph_gap         = utm_pkg::RST_GLYPH_GAP;
		glyph_count       = utm_pkg::RST_GLYPH_COUNT;
		byte_limit        = utm_pkg::RST_BYTE_LIMIT;
		in_string         = 1'b0;
		errors            = 0;
		clear_string();
	endfunction

	function void clear_string();
		seq_left  = 0;
		code      = '0;
		space_seq = 1'b0;
		consumed  = 0;
		pen_x     = 0;
		max_x     = 0;
		line_y    = 0;
		points    = 0;
	endfunction

	function int unsigned clip(int unsigned v, int unsigned lim);
		return (v > lim) ? lim : v;
	endfunction

	function int expected_left();
		return pending_extents.size();
	endfunction

	function void set_reg(logic [2:0] idx, logic [15:0] data);
		case (idx)
			utm_pkg::CFG_GLYPH_HEIGHT:      glyph_height = data[7:0];
			utm_pkg::CFG_MONO_WIDTH:        mono_width = data[7:0];
			utm_pkg::CFG_PROPORTIONAL_MODE: proportional_mode = data[0];
			utm_pkg::CFG_GLYPH_GAP:         glyph_gap = data[7:0];
			utm_pkg::CFG_GLYPH_COUNT:       glyph_count = data[7:0];
			utm_pkg::CFG_BYTE_LIMIT:        byte_limit = data;
			default: ;
		endcase
	endfunction

	// Close the string with one result beat.
	function void close_string(logic st, int unsigned w, int unsigned h);
		extent_t e;
		e.status     = st;
		e.width_px   = 16'(clip(w, utm_pkg::CNT_MAX));
		e.height_px  = 16'(clip(h, utm_pkg::CNT_MAX));
		e.char_count = points[15:0];
		pending_extents.push_back(e);
		in_string = 1'b0;
	endfunction

	// A code point is complete: end the string, break the line or move the pen.
	function void take_point(logic [20:0] cp);
		int unsigned gw;
		int unsigned idx;
		if (cp == 0 || (byte_limit != 0 && consumed >= byte_limit)) begin
			close_string(utm_pkg::STATUS_OK, (max_x > glyph_gap) ? max_x - glyph_gap : 0,
				line_y + glyph_height);
			return;
		end
		if (points < utm_pkg::CNT_MAX)
			points++;
		if (cp == utm_pkg::CP_NEWLINE) begin
			line_y = clip(line_y + glyph_height, EXT_MAX);
			pen_x  = 0;
			return;
		end
		gw = mono_width;
		if (proportional_mode) begin
			if (cp < utm_pkg::FIRST_GLYPH) begin
				close_string(utm_pkg::STATUS_MISSING, 0, 0);
				return;
			end
			idx = cp - utm_pkg::FIRST_GLYPH;
			if (idx >= glyph_count || idx >= GLYPH_DEPTH) begin
				close_string(utm_pkg::STATUS_MISSING, 0, 0);
				return;
			end
			gw = widths[idx];
		end
		pen_x = clip(pen_x + gw + glyph_gap, EXT_MAX);
		if (pen_x > max_x)
			max_x = pen_x;
	endfunction

	// Note an accepted input beat. Returns 0 when the block ignores it.
	function bit note_beat(utm_pkg::item_t it);
		logic [7:0] b;
		if (it.command == utm_pkg::CMD_TABLE) begin
			widths[it.table_index] = it.table_width;
			return 1'b1;
		end
		if (it.first_byte) begin
			clear_string();
			in_string = 1'b1;
		end
		if (!in_string)
			return 1'b0;
		b = it.byte_value;
		if (consumed < utm_pkg::CNT_MAX)
			consumed++;

		// Continuation bytes are taken without checking their top bits.
		if (seq_left != 0) begin
			code = {code[14:0], b[5:0]};
			seq_left--;
			if (seq_left == 0) begin
				if (space_seq) begin
					space_seq = 1'b0;
					take_point(utm_pkg::CP_SPACE);
				end else begin
					take_point(code);
				end
			end
			return 1'b1;
		end

		// Bytes that cannot start a sequence are dropped.
		if ((b >= 8'h80 && b <= 8'hBF) || b == 8'hC0 || b == 8'hC1 ||
			b == 8'hFE || b == 8'hFF)
			return 1'b1;
		if (b <= utm_pkg::ASCII_MAX) begin
			take_point({13'd0, b});
		end else if (b <= utm_pkg::LEAD2_MAX) begin
			code     = {16'd0, b[4:0]};
			seq_left = 1;
		end else if (b <= utm_pkg::LEAD3_MAX) begin
			code     = {17'd0, b[3:0]};
			seq_left = 2;
		end else if (b <= utm_pkg::LEAD4_MAX) begin
			code     = {18'd0, b[2:0]};
			seq_left = 3;
		end else begin
			code      = '0;
			seq_left  = 3;
			space_seq = 1'b1;
		end
		return 1'b1;
	endfunction

	task report(string what, logic [15:0] got, logic [15:0] want);
		$display("%0t ns: %s: got %h, want %h", $time, what, got, want);
		errors++;
	endtask

	// Compare one result beat with the oldest prediction.
	task check_result(logic st, logic [15:0] w, logic [15:0] h, logic [15:0] c);
		extent_t want;
		if (pending_extents.size() == 0) begin
			report("result beat with nothing expected", w, 16'd0);
			return;
		end
		want = pending_extents.pop_front();
		if (st !== want.status)
			report("status", {15'd0, st}, {15'd0, want.status});
		if (w !== want.width_px)
			report("width_px", w, want.width_px);
		if (h !== want.height_px)
			report("height_px", h, want.height_px);
		if (c !== want.char_count)
			report("char_count", c, want.char_count);
	endtask
endclass

module testbench;

	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int          SETTLE_GAP   = 6;
	localparam int          PHASE_ITEMS  = 60;
	localparam int          RANDOM_PHASES = 10;
	localparam logic [2:0]  CFG_SPARE_A  = 3'd6;
	localparam logic [2:0]  CFG_SPARE_B  = 3'd7;
	localparam logic [7:0]  NUL_BYTE     = 8'h00;
	localparam logic [7:0]  LF_BYTE      = 8'h0A;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        command;
	logic        first_byte;
	logic [7:0]  byte_value;
	logic [6:0]  table_index;
	logic [7:0]  table_width;
	logic        out_valid;
	logic        out_stall;
	logic        status;
	logic [15:0] width_px;
	logic [15:0] height_px;
	logic [15:0] char_count;

	extent_scoreboard sb;
	int unsigned      cycles;
	int unsigned      work_items;
	int               stall_hold;
	int               stall_pick;
	bit               no_gaps;
	bit               start_next;

	utf8_text_extent_measure dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.first_byte  (first_byte),
		.byte_value  (byte_value),
		.table_index (table_index),
		.table_width (table_width),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.width_px    (width_px),
		.height_px   (height_px),
		.char_count  (char_count)
	);

	// 100 MHz clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog on the cycle count.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver stalls: mostly short bursts, some long ones, some quiet stretches.
	always @(negedge clk) begin
		if (stall_hold == 0) begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 50) begin
				out_stall <= 1'b0;
				stall_hold = $urandom_range(1, 20);
			end else if (stall_pick < 56) begin
				out_stall <= 1'b0;
				stall_hold = $urandom_range(50, 200);
			end else if (stall_pick < 90) begin
				out_stall <= 1'b1;
				stall_hold = $urandom_range(1, 3);
			end else begin
				out_stall <= 1'b1;
				stall_hold = $urandom_range(8, 40);
			end
		end else begin
			stall_hold = stall_hold - 1;
		end
	end

	// Result beats are checked at the rising edge that accepts them.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, width_px, height_px, char_count);
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Drive the input channel low.
	task automatic hold_input(int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// Present one beat, wait for it to be taken, then maybe idle.
	task automatic send_beat(utm_pkg::item_t it);
		int gap;
		@(negedge clk);
		in_valid    <= 1'b1;
		command     <= it.command;
		first_byte  <= it.first_byte;
		byte_value  <= it.byte_value;
		table_index <= it.table_index;
		table_width <= it.table_width;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (sb.note_beat(it))
			work_items++;
		gap = no_gaps ? 0 : gap_len();
		if (gap != 0)
			hold_input(gap);
	endtask

	// Text byte; the first one after start_next is set opens a new string.
	task automatic send_text(logic [7:0] b);
		utm_pkg::item_t it;
		it.command     = utm_pkg::CMD_TEXT;
		it.first_byte  = start_next;
		it.byte_value  = b;
		it.table_index = 7'($urandom_range(0, 127));
		it.table_width = 8'($urandom_range(0, 255));
		start_next     = 1'b0;
		send_beat(it);
	endtask

	task automatic send_table(logic [6:0] idx, logic [7:0] w);
		utm_pkg::item_t it;
		it.command     = utm_pkg::CMD_TABLE;
		it.first_byte  = 1'($urandom_range(0, 1));
		it.byte_value  = 8'($urandom_range(0, 255));
		it.table_index = idx;
		it.table_width = w;
		send_beat(it);
	endtask

	// Wait until every predicted result has been seen, then let the pipe empty.
	task automatic settle();
		hold_input(1);
		while (sb.expected_left() != 0)
			@(posedge clk);
		repeat (SETTLE_GAP)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Unused upper data bits sometimes carry junk.
	function automatic logic [15:0] with_junk(logic [7:0] v);
		logic [7:0] junk;
		junk = ($urandom_range(0, 9) < 3) ? 8'($urandom_range(0, 255)) : 8'd0;
		return {junk, v};
	endfunction

	task automatic write_all(logic [7:0] h, logic [7:0] m, logic p, logic [7:0] s,
		logic [7:0] c, logic [15:0] lim);
		write_reg(utm_pkg::CFG_GLYPH_HEIGHT, with_junk(h));
		write_reg(utm_pkg::CFG_MONO_WIDTH, with_junk(m));
		write_reg(utm_pkg::CFG_PROPORTIONAL_MODE, with_junk({7'd0, p}) & 16'hFF01 |
			(($urandom_range(0, 3) == 0) ? 16'h0002 : 16'h0000));
		write_reg(utm_pkg::CFG_GLYPH_GAP, with_junk(s));
		write_reg(utm_pkg::CFG_GLYPH_COUNT, with_junk(c));
		write_reg(utm_pkg::CFG_BYTE_LIMIT, lim);
	endtask

	function automatic logic [7:0] pick8();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 8'd0;
		if (r < 30)
			return 8'd255;
		return 8'($urandom_range(0, 255));
	endfunction

	// Continuation byte: payload in the low six bits, top bits mostly 10.
	function automatic logic [7:0] cont_byte(logic [5:0] bits);
		logic [1:0] top;
		top = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3)) : 2'b10;
		return {top, bits};
	endfunction

	function automatic logic [7:0] skip_byte();
		int r;
		r = $urandom_range(0, 67);
		if (r < 64)
			return 8'(8'h80 + r);
		case (r)
			64: return 8'hC0;
			65: return 8'hC1;
			66: return 8'hFE;
			default: return 8'hFF;
		endcase
	endfunction

	// In proportional mode most code points land on a glyph of the font.
	function automatic logic [20:0] pick_point();
		int r;
		int top;
		r = $urandom_range(0, 99);
		if (sb.proportional_mode && sb.glyph_count != 0 && r < 85) begin
			top = (sb.glyph_count > GLYPH_DEPTH) ? GLYPH_DEPTH : sb.glyph_count;
			return utm_pkg::FIRST_GLYPH + 21'($urandom_range(0, top - 1));
		end
		r = $urandom_range(0, 99);
		if (r < 50)
			return 21'($urandom_range('h20, 'h7E));
		if (r < 60)
			return 21'($urandom_range('h01, 'h1F));
		if (r < 75)
			return 21'($urandom_range('h80, 'h7FF));
		if (r < 88)
			return 21'($urandom_range('h800, 'hFFFF));
		return 21'($urandom_range('h10000, 'h1FFFFF));
	endfunction

	// Shortest encoding, sometimes an overlong one.
	function automatic int pick_len(logic [20:0] cp);
		int n;
		n = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
		if (n < 4 && $urandom_range(0, 4) == 0)
			n = $urandom_range((n == 1) ? 3 : n + 1, 4);
		return n;
	endfunction

	task automatic send_point(logic [20:0] cp, int n);
		logic [7:0] seq [4];
		case (n)
			1: seq[0] = {1'b0, cp[6:0]};
			2: begin
				seq[0] = {3'b110, cp[10:6]};
				seq[1] = cont_byte(cp[5:0]);
			end
			3: begin
				seq[0] = {4'b1110, cp[15:12]};
				seq[1] = cont_byte(cp[11:6]);
				seq[2] = cont_byte(cp[5:0]);
			end
			default: begin
				seq[0] = {5'b11110, cp[20:18]};
				seq[1] = cont_byte(cp[17:12]);
				seq[2] = cont_byte(cp[11:6]);
				seq[3] = cont_byte(cp[5:0]);
			end
		endcase
		for (int i = 0; i < n; i++)
			send_text(seq[i]);
	endtask

	// One piece of a string: mostly code points, some noise and broken bytes.
	task automatic send_part();
		int r;
		logic [20:0] cp;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			send_text(LF_BYTE);
		end else if (r < 72) begin
			cp = pick_point();
			send_point(cp, pick_len(cp));
		end else if (r < 77) begin
			// Five and six byte leads decode to a space after three more bytes.
			send_text(8'($urandom_range('hF8, 'hFD)));
			repeat (3)
				send_text(8'($urandom_range(0, 255)));
		end else if (r < 85) begin
			send_text(skip_byte());
		end else if (r < 92) begin
			send_text(8'($urandom_range(0, 255)));
		end else if (r < 97) begin
			send_table(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
		end else begin
			start_next = 1'b1;
		end
	endtask

	task automatic send_string(int parts);
		int r;
		start_next = 1'b1;
		no_gaps    = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < parts; i++)
			send_part();
		r = $urandom_range(0, 99);
		if (r < 80)
			send_text(NUL_BYTE);
		else if (r < 88)
			send_point('0, $urandom_range(3, 4));
		no_gaps = 1'b0;
	endtask

	// Random strings until enough beats have done work.
	task automatic run_strings(int unsigned count);
		int unsigned start;
		int r;
		start = work_items;
		while (work_items - start < count) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				start_next = 1'b0;
				send_text(8'($urandom_range(0, 255)));
			end else if (r < 7) begin
				// Hold off until the block has delivered everything.
				hold_input(1);
				while (sb.expected_left() != 0)
					@(posedge clk);
			end else if (r < 97) begin
				send_string($urandom_range(0, 12));
			end else if (r < 99) begin
				send_string($urandom_range(13, 40));
			end else begin
				send_string($urandom_range(60, 150));
			end
		end
	endtask

	// Close any open string with an empty one, then wait for the pipe to drain.
	task automatic end_phase();
		start_next = 1'b1;
		send_text(NUL_BYTE);
		settle();
	endtask

	task automatic random_config();
		int r;
		logic [7:0]  s;
		logic [7:0]  c;
		logic [15:0] lim;
		s = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : pick8();
		r = $urandom_range(0, 99);
		c = (r < 30) ? 8'd96 : (r < 50) ? 8'd128 : (r < 60) ? 8'd0 :
			(r < 70) ? 8'd255 : 8'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		lim = (r < 55) ? 16'd0 : (r < 85) ? 16'($urandom_range(1, 40)) :
			(r < 90) ? 16'hFFFF : 16'($urandom_range(0, 65535));
		write_all(pick8(), pick8(), 1'($urandom_range(0, 1)), s, c, lim);
	endtask

	initial begin
		sb          = new();
		cycles      = 0;
		work_items  = 0;
		stall_hold  = 0;
		no_gaps     = 1'b0;
		start_next  = 1'b0;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		command     = utm_pkg::CMD_TEXT;
		first_byte  = 1'b0;
		byte_value  = '0;
		table_index = '0;
		table_width = '0;
		out_stall   = 1'b0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Fill the whole width table so proportional mode never reads a blank entry.
		for (int i = 0; i < GLYPH_DEPTH; i++)
			send_table(7'(i), (i == 0) ? 8'd0 : (i == 1) ? 8'd255 :
				8'($urandom_range(0, 255)));

		// Directed strings at the reset register values.
		start_next = 1'b1;
		send_text(8'h48);
		send_text(8'h69);
		send_text(LF_BYTE);
		send_text(8'hFF);
		send_text(8'h80);
		send_text(8'hC0);
		send_text(8'hC1);
		send_text(8'hFE);
		send_point(21'h7FF, 2);
		send_point(21'hFFFF, 3);
		send_point(21'h1FFFFF, 4);
		send_text(8'hFB);
		repeat (3)
			send_text(NUL_BYTE);
		send_text(utm_pkg::ASCII_MAX);
		send_text(NUL_BYTE);
		// A three byte sequence that decodes to zero ends the string.
		start_next = 1'b1;
		send_point('0, 3);
		// Text with no string open is ignored.
		send_text(8'h78);
		// A new first byte abandons the string in progress.
		start_next = 1'b1;
		send_text(8'h61);
		send_text(8'h62);
		start_next = 1'b1;
		send_text(8'h63);
		send_text(NUL_BYTE);
		settle();

		// Largest settings: pen and line offsets saturate.
		write_all(8'd255, 8'd255, 1'b0, 8'd255, 8'd255, 16'hFFFF);
		write_reg(CFG_SPARE_A, 16'hFFFF);
		write_reg(CFG_SPARE_B, 16'h5A5A);
		start_next = 1'b1;
		repeat (140)
			send_text(8'h4D);
		repeat (260)
			send_text(LF_BYTE);
		send_text(8'h4D);
		send_text(NUL_BYTE);
		run_strings(40);
		end_phase();

		// Proportional widths: last table glyph, glyph past the table, control code.
		write_all(8'd1, 8'd0, 1'b1, 8'd0, 8'd255, 16'd0);
		start_next = 1'b1;
		send_text(8'h41);
		send_point(21'h9F, 2);
		send_point(21'hA0, 2);
		start_next = 1'b1;
		send_text(8'h07);
		start_next = 1'b1;
		send_text(LF_BYTE);
		send_text(8'h7E);
		send_text(NUL_BYTE);
		run_strings(40);
		end_phase();

		// Smallest settings: an empty font and a one-byte limit.
		write_all(8'd1, 8'd0, 1'b1, 8'd0, 8'd0, 16'd1);
		run_strings(30);
		end_phase();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_config();
			run_strings(PHASE_ITEMS);
			end_phase();
		end

		repeat (20)
			@(posedge clk);
		if (sb.errors == 0 && sb.expected_left() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
